[hdl/sorted_priority_list_defines.svh]
// Assertion macros for the sorted priority list block.
// Taken in by spl_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef SORTED_PRIORITY_LIST_DEFINES_SVH
`define SORTED_PRIORITY_LIST_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define SPL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SPL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/spl_pkg.sv]
// Shared types and codes for the sorted priority list.
// No dependencies; used by spl_ctrl, sorted_priority_list and the testbench.
package spl_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_WIDTH_DEF = 16;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  priority_req;
    logic [15:0] tag;
    logic [3:0]  index;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [15:0] out_tag;
    logic [4:0]  count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

[hdl/spl_ram.sv]
// Simple dual-port entry memory: one write port, one registered read port.
// No dependencies.
module spl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/spl_ctrl.sv]
// Sequencer for the sorted priority list: decodes a request, walks the entry
// memory from the tail for inserts, and produces one response word.
// Depends on spl_pkg and sorted_priority_list_defines.svh.
`include "sorted_priority_list_defines.svh"
module spl_ctrl #(
  parameter int DEPTH     = spl_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spl_pkg::TAG_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  spl_pkg::req_word_t                req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output spl_pkg::rsp_word_t                res,
  output logic                              we,
  output logic [$clog2(DEPTH)-1:0]          waddr,
  output logic [8+TAG_WIDTH-1:0]            wdata,
  output logic                              re,
  output logic [$clog2(DEPTH)-1:0]          raddr,
  input  logic [8+TAG_WIDTH-1:0]            rdata
);
  import spl_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int EW   = 8 + TAG_WIDTH;

  state_t          state, state_next;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   k;
  logic            first;
  logic [7:0]      head_pri;
  req_word_t       op;

  logic [7:0]      cur_pri;
  logic            shift;
  logic            is_full;
  logic            is_empty;
  logic            idx_bad;
  logic [CMPW-1:0] idx_w;
  logic [AW-1:0]   tail_addr;
  logic [EW-1:0]   req_entry;
  logic [EW-1:0]   op_entry;

  assign cur_pri   = rdata[EW-1:TAG_WIDTH];
  assign is_full   = (cnt == CW'(DEPTH));
  assign is_empty  = (cnt == '0);
  assign idx_w     = CMPW'(req.index);
  assign idx_bad   = (idx_w >= CMPW'(cnt));
  assign tail_addr = AW'(cnt - CW'(1));
  assign req_entry = {req.priority_req, TAG_WIDTH'(req.tag)};
  assign op_entry  = {op.priority_req, TAG_WIDTH'(op.tag)};

  // At the tail an equal priority moves up only when every entry equals it
  // (new entry then belongs at the head); further down, equal entries move up.
  assign shift = (op.priority_req < cur_pri) ||
                 ((op.priority_req == cur_pri) &&
                  (!first || (op.priority_req <= head_pri)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.func)
            FUNC_INSERT: state_next = (is_full || is_empty) ? ST_DONE : ST_SHIFT;
            FUNC_POP:    state_next = is_empty ? ST_DONE : ST_FETCH;
            FUNC_READ:   state_next = idx_bad ? ST_DONE : ST_FETCH;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_FETCH: state_next = ST_DONE;
      ST_SHIFT: begin
        if (!shift) begin
          state_next = ST_DONE;
        end else if (k == '0) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    req_ready = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.func)
            FUNC_INSERT: begin
              if (!is_full && is_empty) begin
                we    = 1'b1;
                wdata = req_entry;
              end else if (!is_full) begin
                re    = 1'b1;
                raddr = tail_addr;
              end
            end
            FUNC_POP: begin
              re    = !is_empty;
              raddr = tail_addr;
            end
            FUNC_READ: begin
              re    = !idx_bad;
              raddr = idx_w[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = k + AW'(1);
        wdata = shift ? rdata : op_entry;
        re    = shift && (k != '0);
        raddr = k - AW'(1);
      end
      ST_PLACE: begin
        we    = 1'b1;
        wdata = op_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            if (req.func == FUNC_INSERT && !is_full) begin
              cnt <= is_empty ? CW'(1) : cnt;
            end else if (req.func == FUNC_POP && !is_empty) begin
              cnt <= cnt - CW'(1);
            end
          end
        end
        ST_SHIFT: begin
          if (!shift) begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_PLACE: cnt <= cnt + CW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op                 <= req;
          k                  <= tail_addr;
          first              <= 1'b1;
          res.status         <= STAT_OK;
          res.out_priority   <= '0;
          res.out_tag        <= '0;
          res.count          <= 5'(cnt);
          case (req.func)
            FUNC_INSERT: begin
              if (is_full) begin
                res.status <= STAT_FULL;
              end else if (is_empty) begin
                head_pri  <= req.priority_req;
                res.count <= 5'(CW'(1));
              end
            end
            FUNC_POP: begin
              if (is_empty) begin
                res.status <= STAT_EMPTY;
              end
            end
            FUNC_READ: begin
              if (idx_bad) begin
                res.status <= STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        res.out_priority <= cur_pri;
        res.out_tag      <= 16'(rdata[TAG_WIDTH-1:0]);
        res.count        <= 5'(cnt);
      end
      ST_SHIFT: begin
        if (shift) begin
          k     <= k - AW'(1);
          first <= 1'b0;
        end else begin
          res.count <= 5'(cnt + CW'(1));
        end
      end
      ST_PLACE: begin
        head_pri  <= op.priority_req;
        res.count <= 5'(cnt + CW'(1));
      end
      default: ;
    endcase
  end

  `SPL_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(DEPTH))
  `SPL_ASSERT_IMP(a_port_split, clk, rst, we && re, waddr != raddr)
  `SPL_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SHIFT, CW'(k) < cnt)
  `SPL_ASSERT_IMP(a_full_cnt, clk, rst, res_valid && res.status == STAT_FULL, cnt == CW'(DEPTH))
  `SPL_ASSERT_NEXT(a_place_grow, clk, rst, state == ST_PLACE, cnt == $past(cnt) + CW'(1))

endmodule

[hdl/sorted_priority_list.sv]
// Top level of the sorted priority list: sequencer, entry memory and the
// response register. Depends on spl_pkg, spl_ctrl and spl_ram.
//
//   channel | signals                  | word
//   --------+--------------------------+--------------------------------------
//   request | req_valid, req_ready     | req: func, priority_req, tag, index
//   response| rsp_valid, rsp_ready     | rsp: status, out_priority, out_tag, count
//
// Read and pop pass through a fetch state; a refused or trivial request goes
// straight to the response. An insert walks the memory from the tail, one
// entry per cycle through the single write port.
// Reset only clears the count and control; memory contents are left as they are.
// A held response does not block the next request; a finished one waits until
// the response register is free.
module sorted_priority_list #(
  parameter int DEPTH     = spl_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spl_pkg::TAG_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  spl_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output spl_pkg::rsp_word_t rsp
);
  import spl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = 8 + TAG_WIDTH;

  logic          res_valid;
  logic          res_ready;
  rsp_word_t     res;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  assign res_ready = !rsp_valid || rsp_ready;

  spl_ctrl #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  spl_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

[test/sorted_priority_list_tb.sv]
// Self-checking testbench for sorted_priority_list: directed placement, full and empty
// cases, then random insert/pop/read traffic with optional random gaps per channel.
// Depends on spl_pkg and the sorted_priority_list RTL.
module sorted_priority_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spl_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = DEPTH + 8;
  localparam int MAX_PRINTED    = 40;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  sorted_priority_list #(
    .DEPTH(DEPTH),
    .TAG_WIDTH(TAG_WIDTH_DEF)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  // predicted contents of the list, ascending priority
  logic [7:0]  prio_mem [DEPTH];
  logic [15:0] tag_mem  [DEPTH];
  int          fill_level = 0;

  rsp_word_t pending_rsp [$];
  int        mismatches = 0;
  bit        src_idle   = 1'b1;
  bit        sink_idle  = 1'b1;

  function automatic rsp_word_t apply_to_list(input req_word_t w);
    rsp_word_t r;
    int pos;
    int k;
    r = '0;
    r.status = STAT_OK;
    case (w.func)
      FUNC_INSERT: begin
        if (fill_level >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // head wins on a tie with entry 0, tail wins on a tie with the last entry
          if (fill_level == 0 || w.priority_req <= prio_mem[0]) begin
            pos = 0;
          end else if (w.priority_req >= prio_mem[fill_level-1]) begin
            pos = fill_level;
          end else begin
            pos = 1;
            while (pos < fill_level && w.priority_req > prio_mem[pos]) pos++;
          end
          for (k = fill_level; k > pos; k--) begin
            prio_mem[k] = prio_mem[k-1];
            tag_mem[k]  = tag_mem[k-1];
          end
          prio_mem[pos] = w.priority_req;
          tag_mem[pos]  = w.tag;
          fill_level++;
        end
      end
      FUNC_POP: begin
        if (fill_level == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          fill_level--;
          r.out_priority = prio_mem[fill_level];
          r.out_tag      = tag_mem[fill_level];
        end
      end
      FUNC_READ: begin
        if (int'(w.index) >= fill_level) begin
          r.status = STAT_RANGE;
        end else begin
          r.out_priority = prio_mem[w.index];
          r.out_tag      = tag_mem[w.index];
        end
      end
      default: begin
      end
    endcase
    r.count = 5'(fill_level);
    return r;
  endfunction

  function automatic req_word_t make_word(input logic [1:0] func, input logic [7:0] pri,
                                          input logic [15:0] tag, input logic [3:0] index);
    req_word_t w;
    w.func         = func;
    w.priority_req = pri;
    w.tag          = tag;
    w.index        = index;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < MAX_PRINTED)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // one request word; the expected response is queued when the word is taken
  task automatic send_word(input req_word_t w);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(apply_to_list(w));
  endtask

  initial begin : rsp_sink
    int stall;
    forever begin
      stall = sink_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_valid && !rst)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected word", 0, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", want.status, rsp.status);
        if (rsp.out_priority !== want.out_priority)
          report_mismatch("out_priority", want.out_priority, rsp.out_priority);
        if (rsp.out_tag !== want.out_tag)
          report_mismatch("out_tag", want.out_tag, rsp.out_tag);
        if (rsp.count !== want.count)
          report_mismatch("count", want.count, rsp.count);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_empty_store;
    send_word(make_word(FUNC_POP, 8'hFF, 16'hFFFF, 4'hF));
    send_word(make_word(FUNC_READ, 8'h00, 16'h0000, 4'hF));
    send_word(make_word(FUNC_NOP, 8'($urandom), 16'($urandom), 4'($urandom)));
    send_word(make_word(FUNC_INSERT, 8'h07, 16'hA5A5, 4'h0));
    // popping the only entry leaves the list empty
    send_word(make_word(FUNC_POP, 8'h00, 16'h0000, 4'h0));
    send_word(make_word(FUNC_POP, 8'h00, 16'h0000, 4'h0));
  endtask

  task automatic test_placement;
    send_word(make_word(FUNC_INSERT, 8'd128, 16'h0000, 4'h0));
    send_word(make_word(FUNC_INSERT, 8'd255, 16'hFFFF, 4'hF));
    send_word(make_word(FUNC_INSERT, 8'd0,   16'h0001, 4'h0));
    send_word(make_word(FUNC_INSERT, 8'd64,  16'h1234, 4'h0));
    send_word(make_word(FUNC_INSERT, 8'd128, 16'h5A5A, 4'h0));
    send_word(make_word(FUNC_INSERT, 8'd0,   16'h8000, 4'h0));
    send_word(make_word(FUNC_INSERT, 8'd255, 16'h7FFF, 4'h0));
    send_word(make_word(FUNC_READ, 8'h00, 16'h0000, 4'd3));
    send_word(make_word(FUNC_READ, 8'h00, 16'h0000, 4'd7));
    send_word(make_word(FUNC_POP, 8'h00, 16'h0000, 4'h0));
  endtask

  task automatic test_full_store;
    while (fill_level < DEPTH)
      send_word(make_word(FUNC_INSERT, 8'($urandom), 16'($urandom), 4'($urandom)));
    send_word(make_word(FUNC_INSERT, 8'h00, 16'hFFFF, 4'h0));
    send_word(make_word(FUNC_READ, 8'h00, 16'h0000, 4'hF));
    send_word(make_word(FUNC_POP, 8'h00, 16'h0000, 4'h0));
  endtask

  // weights in percent; span is the width of the priority band used
  task automatic run_traffic(input int n, input int ins_w, input int pop_w, input int span,
                             input bit src_gap, input bit sink_gap);
    req_word_t w;
    int issued;
    int roll;
    int base;
    src_idle  = src_gap;
    sink_idle = sink_gap;
    base      = $urandom_range(0, 256 - span);
    issued    = 0;
    while (issued < n) begin
      w = req_word_t'($urandom);
      w.priority_req = 8'(base + $urandom_range(0, span - 1));
      roll = $urandom_range(0, 99);
      if (roll < ins_w) begin
        w.func = FUNC_INSERT;
      end else if (roll < ins_w + pop_w) begin
        w.func = FUNC_POP;
      end else if (roll < 98) begin
        w.func = FUNC_READ;
        if (fill_level > 0 && $urandom_range(0, 3) != 0)
          w.index = 4'($urandom_range(0, fill_level - 1));
      end else begin
        w.func = FUNC_NOP;
      end
      send_word(w);
      if (w.func != FUNC_NOP) issued++;
    end
  endtask

  task automatic test_fill_pressure;
    run_traffic(275, 70, 15, 256, 1'b1, 1'b1);
  endtask

  task automatic test_drain_pressure;
    run_traffic(275, 20, 65, 256, 1'b1, 1'b1);
  endtask

  task automatic test_equal_priorities;
    run_traffic(275, 45, 35, 3, 1'b1, 1'b1);
  endtask

  task automatic test_mixed_traffic;
    run_traffic(275, 45, 35, 256, 1'b0, 1'b0);
    run_traffic(275, 50, 35, 16, 1'b0, 1'b1);
    run_traffic(275, 45, 40, 256, 1'b1, 1'b0);
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_placement();
    test_full_store();
    test_fill_pressure();
    test_drain_pressure();
    test_equal_priorities();
    test_mixed_traffic();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[sorted_priority_list.f]
+incdir+hdl
hdl/spl_pkg.sv
hdl/spl_ram.sv
hdl/spl_ctrl.sv
hdl/sorted_priority_list.sv
test/sorted_priority_list_tb.sv
